FILE: hdl/enhanced_second_chance_victim_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clock victim core
// Immediate-consequence and next-cycle property wrappers on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef ENHANCED_SECOND_CHANCE_VICTIM_CORE_MACROS_SVH
`define ENHANCED_SECOND_CHANCE_VICTIM_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ESCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ESCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/escv_pkg.sv
// ----------------------------------------------------------------------------
// escv_pkg
// Types, codes and field widths for the clock victim selection core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package escv_pkg;

  // Default geometry
  localparam int NUM_FRAMES_DEF = 64;
  localparam int PID_WIDTH_DEF  = 8;

  // Stream field widths
  localparam int OP_W        = 2;
  localparam int PID_W       = 8;
  localparam int FRAME_W     = 6;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = FRAME_W + PID_W;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REFER   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;

  // Search pass numbering
  localparam int PASS_W = 2;
  localparam logic [PASS_W-1:0] PASS_FIRST = 2'd0;
  localparam logic [PASS_W-1:0] PASS_CLEAR = 2'd1;
  localparam logic [PASS_W-1:0] PASS_LAST  = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_VICTIM = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_ERROR  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS1,
    S_INS2,
    S_REFW,
    S_SRCH,
    S_FALLBACK,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t              status;
    logic [FRAME_W-1:0]   frame;
    logic [PID_W-1:0]     pid;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/enhanced_second_chance_victim_core.sv
// A rejected or unused-code request goes straight to the result; a reference sets ref,
//   and dirty on a write; an insert writes the entry, then splices it in unless the ring
//   was empty; a replace searches up to four passes of the ring, else takes the hand.
// One request at a time; a new one can be taken in the cycle after the result is loaded
//   into the output register, and none while out_tready holds off the previous result.
// Reset: synchronous active-low; clears FSM, hand, count, resident bits, output valid.
// ----------------------------------------------------------------------------
// enhanced_second_chance_victim_core
// Enhanced second-chance clock replacement over a linked ring of frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "enhanced_second_chance_victim_core_macros.svh"

module enhanced_second_chance_victim_core #(
  parameter int NUM_FRAMES = escv_pkg::NUM_FRAMES_DEF,
  parameter int PID_WIDTH  = escv_pkg::PID_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] owner_pid, [13:8] frame_number, [14] ref_in, [15] dirty_in
  input  logic [escv_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [escv_pkg::OP_W-1:0]        in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [5:0] victim_frame, [13:6] victim_pid, [15:14] zero
  output logic [escv_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [escv_pkg::STATUS_W-1:0]    out_tuser
);

  import escv_pkg::*;

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);

  // request fields
  logic [PID_W-1:0]   in_pid;
  logic [FRAME_W-1:0] in_frame;
  logic               in_ref;
  logic               in_dirty;
  logic [AW-1:0]      in_idx;
  logic               in_valid_frame;
  logic               in_resident;

  // control state
  state_t              state_r, state_nxt;
  logic [AW-1:0]       hand_r, hand_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [NUM_FRAMES-1:0] resident_r, resident_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload state
  logic [AW-1:0]        frame_r, frame_nxt;
  logic [PID_WIDTH-1:0] pid_r, pid_nxt;
  logic                 ref_in_r, ref_in_nxt;
  logic                 dirty_in_r, dirty_in_nxt;
  logic [AW-1:0]        p_r, p_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [PASS_W-1:0]    pass_r, pass_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  res_t                 res_r, res_nxt;
  res_t                 out_res_r, out_res_nxt;

  // memories
  logic [AW-1:0]        next_mem  [NUM_FRAMES];
  logic [AW-1:0]        prev_mem  [NUM_FRAMES];
  logic [PID_WIDTH-1:0] owner_mem [NUM_FRAMES];
  logic                 ref_mem   [NUM_FRAMES];
  logic                 dirty_mem [NUM_FRAMES];

  logic [AW-1:0]        next_rd_r, prev_rd_r;
  logic [PID_WIDTH-1:0] owner_rd_r;
  logic                 ref_rd_r, dirty_rd_r;

  logic [AW-1:0]        rd_addr;
  logic                 next_we, prev_we, owner_we, ref_we, dirty_we;
  logic [AW-1:0]        next_waddr, prev_waddr, ref_waddr, dirty_waddr;
  logic [AW-1:0]        next_wdata, prev_wdata;
  logic                 ref_wdata, dirty_wdata;

  // decode helpers
  logic ins_err, ref_err, repl_empty;
  logic match, last_in_pass, out_free;

  // --------------------------------------------------------------------------
  // Field unpack and request checks
  // --------------------------------------------------------------------------
  assign in_pid         = in_tdata[PID_W-1:0];
  assign in_frame       = in_tdata[PID_W +: FRAME_W];
  assign in_ref         = in_tdata[PID_W + FRAME_W];
  assign in_dirty       = in_tdata[PID_W + FRAME_W + 1];
  assign in_idx         = AW'(in_frame);
  assign in_valid_frame = int'(in_frame) < NUM_FRAMES;
  assign in_resident    = in_valid_frame && resident_r[in_idx];

  assign ins_err    = !in_valid_frame || in_resident;
  assign ref_err    = !in_resident;
  assign repl_empty = count_r == '0;

  // search compare on the entry read last cycle
  assign match        = !ref_rd_r && (dirty_rd_r == pass_r[0]);
  assign last_in_pass = (n_r + CW'(1)) == count_r;
  assign out_free     = !out_valid_r || out_tready;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            OP_INSERT:  state_nxt = ins_err ? S_RESP : S_INS1;
            OP_REFER:   state_nxt = ref_err ? S_RESP : S_REFW;
            OP_REPLACE: state_nxt = repl_empty ? S_RESP : S_SRCH;
            default:    state_nxt = S_RESP;
          endcase
        end
      end
      S_INS1:     state_nxt = (count_r == '0) ? S_RESP : S_INS2;
      S_INS2:     state_nxt = S_RESP;
      S_REFW:     state_nxt = S_RESP;
      S_SRCH: begin
        if (match) begin
          state_nxt = S_RESP;
        end else if (last_in_pass && pass_r == PASS_LAST) begin
          state_nxt = S_FALLBACK;
        end
      end
      S_FALLBACK: state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready     = 1'b0;
    rd_addr       = hand_r;
    frame_nxt     = frame_r;
    pid_nxt       = pid_r;
    ref_in_nxt    = ref_in_r;
    dirty_in_nxt  = dirty_in_r;
    hand_nxt      = hand_r;
    count_nxt     = count_r;
    resident_nxt  = resident_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    pass_nxt      = pass_r;
    tail_nxt      = tail_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;

    next_we     = 1'b0;
    next_waddr  = frame_r;
    next_wdata  = hand_r;
    prev_we     = 1'b0;
    prev_waddr  = frame_r;
    prev_wdata  = prev_rd_r;
    owner_we    = 1'b0;
    ref_we      = 1'b0;
    ref_waddr   = frame_r;
    ref_wdata   = ref_in_r;
    dirty_we    = 1'b0;
    dirty_waddr = frame_r;
    dirty_wdata = dirty_in_r;

    unique case (state_r)
      // capture request; memories read at the hand this cycle
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          frame_nxt    = in_idx;
          pid_nxt      = PID_WIDTH'(in_pid);
          ref_in_nxt   = in_ref;
          dirty_in_nxt = in_dirty;
          p_nxt        = hand_r;
          n_nxt        = '0;
          pass_nxt     = PASS_FIRST;
          res_nxt      = '{status: ST_DONE, frame: '0, pid: '0};
          case (in_tuser)
            OP_INSERT:  if (ins_err) res_nxt.status = ST_ERROR;
            OP_REFER:   if (ref_err) res_nxt.status = ST_ERROR;
            OP_REPLACE: if (repl_empty) res_nxt.status = ST_EMPTY;
            default: ;
          endcase
        end
      end

      // insert: entry fields and own links (prev_rd_r holds prev of hand)
      S_INS1: begin
        resident_nxt[frame_r] = 1'b1;
        owner_we = 1'b1;
        ref_we   = 1'b1;
        dirty_we = 1'b1;
        next_we  = 1'b1;
        prev_we  = 1'b1;
        if (count_r == '0) begin
          next_wdata = frame_r;
          prev_wdata = frame_r;
          hand_nxt   = frame_r;
          count_nxt  = CW'(1);
        end else begin
          tail_nxt = prev_rd_r;
        end
      end

      // insert: splice between tail and hand
      S_INS2: begin
        next_we    = 1'b1;
        next_waddr = tail_r;
        next_wdata = frame_r;
        prev_we    = 1'b1;
        prev_waddr = hand_r;
        prev_wdata = frame_r;
        count_nxt  = count_r + CW'(1);
      end

      // reference: set ref, set dirty on a write
      S_REFW: begin
        ref_we      = 1'b1;
        ref_wdata   = 1'b1;
        dirty_we    = dirty_in_r;
        dirty_wdata = 1'b1;
      end

      // one ring entry per cycle
      S_SRCH: begin
        if (match) begin
          next_we      = 1'b1;
          next_waddr   = prev_rd_r;
          next_wdata   = next_rd_r;
          prev_we      = 1'b1;
          prev_waddr   = next_rd_r;
          prev_wdata   = prev_rd_r;
          resident_nxt[p_r] = 1'b0;
          hand_nxt     = next_rd_r;
          count_nxt    = count_r - CW'(1);
          res_nxt.status = ST_VICTIM;
          res_nxt.frame  = FRAME_W'(p_r);
          res_nxt.pid    = PID_W'(owner_rd_r);
        end else begin
          if (pass_r == PASS_CLEAR) begin
            ref_we    = 1'b1;
            ref_waddr = p_r;
            ref_wdata = 1'b0;
          end
          if (last_in_pass) begin
            n_nxt    = '0;
            p_nxt    = hand_r;
            rd_addr  = hand_r;
            pass_nxt = pass_r + PASS_W'(1);
          end else begin
            n_nxt   = n_r + CW'(1);
            p_nxt   = next_rd_r;
            rd_addr = next_rd_r;
          end
        end
      end

      // no class matched: take the hand itself
      S_FALLBACK: begin
        next_we      = 1'b1;
        next_waddr   = prev_rd_r;
        next_wdata   = next_rd_r;
        prev_we      = 1'b1;
        prev_waddr   = next_rd_r;
        prev_wdata   = prev_rd_r;
        resident_nxt[p_r] = 1'b0;
        hand_nxt     = next_rd_r;
        count_nxt    = count_r - CW'(1);
        res_nxt.status = ST_VICTIM;
        res_nxt.frame  = FRAME_W'(p_r);
        res_nxt.pid    = PID_W'(owner_rd_r);
      end

      // hand result to the output register
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end

      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hand_r      <= '0;
      count_r     <= '0;
      resident_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hand_r      <= hand_nxt;
      count_r     <= count_nxt;
      resident_r  <= resident_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    frame_r    <= frame_nxt;
    pid_r      <= pid_nxt;
    ref_in_r   <= ref_in_nxt;
    dirty_in_r <= dirty_in_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    pass_r     <= pass_nxt;
    tail_r     <= tail_nxt;
    res_r      <= res_nxt;
    out_res_r  <= out_res_nxt;
  end

  // --------------------------------------------------------------------------
  // Link, flag and owner memories; registered reads at one shared read address
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (owner_we) begin
      owner_mem[frame_r] <= pid_r;
    end
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (dirty_we) begin
      dirty_mem[dirty_waddr] <= dirty_wdata;
    end
    next_rd_r  <= next_mem[rd_addr];
    prev_rd_r  <= prev_mem[rd_addr];
    owner_rd_r <= owner_mem[rd_addr];
    dirty_rd_r <= dirty_mem[rd_addr];
    // write-first so a single-entry ring sees its own cleared ref bit
    ref_rd_r   <= (ref_we && ref_waddr == rd_addr) ? ref_wdata : ref_mem[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Output port
  // --------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.pid, out_res_r.frame};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ESCV_ASSERT_NOW(a_search_nonempty, state_r == S_SRCH || state_r == S_FALLBACK,
                   count_r != '0, "search running on an empty ring")
  `ESCV_ASSERT_NEXT(a_victim_unlinked, state_r == S_SRCH && match,
                    !resident_r[$past(p_r)] && (count_r + CW'(1)) == $past(count_r),
                    "victim not removed from ring")
  `ESCV_ASSERT_NEXT(a_insert_resident, state_r == S_INS1,
                    resident_r[frame_r] && count_r != '0, "inserted frame not resident")

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the enhanced second-chance victim core. Requests
// go in on the input stream with random gaps. Every request is predicted by
// a scoreboard that keeps its own copy of the frame ring, flags, owners and
// hand. Each answer on the result stream is compared field by field against
// the oldest prediction. The result side stalls at random and holds off once
// for a long stretch, so the core has to stall its input.
// ----------------------------------------------------------------------------

module testbench;
  import escv_pkg::*;

  localparam int FRAMES          = NUM_FRAMES_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS    = 400;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int HOLD_OFF_AT     = 120;
  // A full-ring search visits up to 4 * 64 entries; allow for that plus the long hold
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 300;

  // Ring state mirror and queue of answers still owed by the core
  class clock_victim_sb;
    bit                 live[FRAMES];
    bit                 refd[FRAMES];
    bit                 dirty[FRAMES];
    logic [FRAME_W-1:0] fwd[FRAMES];
    logic [FRAME_W-1:0] back[FRAMES];
    logic [PID_W-1:0]   owner[FRAMES];
    logic [FRAME_W-1:0] hand = '0;
    int                 depth = 0;
    int                 peak = 0;
    res_t               answers_due[$];
    int                 mismatches = 0;
    int                 n_ins = 0, n_ref = 0, n_rep = 0, n_victims = 0, n_flagged = 0;

    // One clock sweep from the hand; optionally clears ref bits passed over
    function bit sweep(bit want_dirty, bit clear_ref, output logic [FRAME_W-1:0] hit);
      logic [FRAME_W-1:0] p;
      p   = hand;
      hit = '0;
      for (int n = 0; n < depth; n++) begin
        if (!refd[p] && dirty[p] == want_dirty) begin
          hit = p;
          return 1'b1;
        end
        if (clear_ref) refd[p] = 1'b0;
        p = fwd[p];
      end
      return 1'b0;
    endfunction

    // Apply an accepted request and queue the answer it should produce
    function void note_request(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                               logic [FRAME_W-1:0] f, bit r, bit d);
      res_t               ans;
      logic [FRAME_W-1:0] tail, v, a, b;
      ans = '{ST_DONE, '0, '0};
      case (op)
        OP_INSERT: begin
          n_ins++;
          if (live[f]) begin
            ans.status = ST_ERROR;
            n_flagged++;
          end else begin
            live[f]  = 1'b1;
            refd[f]  = r;
            dirty[f] = d;
            owner[f] = pid;
            if (depth == 0) begin
              // first frame links to itself and takes the hand
              fwd[f]  = f;
              back[f] = f;
              hand    = f;
              depth   = 1;
            end else begin
              // splice in just before the hand
              tail       = back[hand];
              back[f]    = tail;
              fwd[f]     = hand;
              fwd[tail]  = f;
              back[hand] = f;
              depth++;
            end
            if (depth > peak) peak = depth;
          end
        end
        OP_REFER: begin
          n_ref++;
          if (!live[f]) begin
            ans.status = ST_ERROR;
            n_flagged++;
          end else begin
            refd[f] = 1'b1;
            if (d) dirty[f] = 1'b1;
          end
        end
        OP_REPLACE: begin
          n_rep++;
          if (depth == 0) begin
            ans.status = ST_EMPTY;
            n_flagged++;
          end else begin
            // clean, dirty with clearing, clean again, dirty again
            if (!sweep(1'b0, 1'b0, v) && !sweep(1'b1, 1'b1, v) &&
                !sweep(1'b0, 1'b0, v) && !sweep(1'b1, 1'b0, v))
              v = hand;
            a       = back[v];
            b       = fwd[v];
            fwd[a]  = b;
            back[b] = a;
            live[v] = 1'b0;
            hand    = b;
            depth--;
            ans = '{ST_VICTIM, v, owner[v]};
            n_victims++;
          end
        end
        default: ;
      endcase
      answers_due.push_back(ans);
    endfunction

    // Compare one accepted answer with the oldest outstanding prediction
    function void check_result(logic [STATUS_W-1:0] st, logic [FRAME_W-1:0] frame,
                               logic [PID_W-1:0] pid, logic [OUT_PAD_W-1:0] pad);
      res_t want;
      if (answers_due.size() == 0) begin
        $error("answer with no request outstanding: status %0d frame %0d pid %0d",
               st, frame, pid);
        mismatches++;
        return;
      end
      want = answers_due.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (frame !== want.frame) begin
        $error("victim_frame: expected %0d, actual %0d", want.frame, frame);
        mismatches++;
      end
      if (pid !== want.pid) begin
        $error("victim_pid: expected %0d, actual %0d", want.pid, pid);
        mismatches++;
      end
      if (pad !== '0) begin
        $error("tdata padding: expected 0, actual %0d", pad);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  clock_victim_sb sb = new;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  int results_seen = 0;
  int idle_cycles = 0;

  enhanced_second_chance_victim_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one request after a random gap and wait for it to be taken
  task automatic send_request(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                              input logic [FRAME_W-1:0] f, input bit r, input bit d);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 18);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d, r, f, pid};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, pid, f, r, d);
    if ($urandom_range(0, 29) == 0) quiet_in = ~quiet_in;
  endtask

  // Random frame that is (or is not) resident, scanning from a random start
  function automatic logic [FRAME_W-1:0] pick_frame(bit want_live);
    int start;
    start = $urandom_range(0, FRAMES - 1);
    for (int k = 0; k < FRAMES; k++)
      if (sb.live[(start + k) % FRAMES] == want_live)
        return FRAME_W'((start + k) % FRAMES);
    return FRAME_W'(start);
  endfunction

  // Edge cases: empty ring, duplicates, absent frames, each search pass
  task automatic run_directed();
    send_request(OP_REPLACE, 8'h00, 6'd0,  1'b0, 1'b0);
    send_request(OP_REFER,   8'h00, 6'd5,  1'b0, 1'b1);
    send_request(OP_UNUSED,  8'hff, 6'd63, 1'b1, 1'b1);
    send_request(OP_INSERT,  8'h00, 6'd0,  1'b0, 1'b0);
    send_request(OP_INSERT,  8'h11, 6'd0,  1'b1, 1'b1);
    // removing the only frame leaves a stale hand
    send_request(OP_REPLACE, 8'h00, 6'd0,  1'b0, 1'b0);
    send_request(OP_INSERT,  8'hff, 6'd63, 1'b1, 1'b1);
    send_request(OP_INSERT,  8'ha5, 6'd10, 1'b1, 1'b0);
    send_request(OP_INSERT,  8'h5a, 6'd21, 1'b0, 1'b1);
    send_request(OP_INSERT,  8'h3c, 6'd42, 1'b0, 1'b0);
    send_request(OP_REFER,   8'h00, 6'd42, 1'b0, 1'b1);
    send_request(OP_REFER,   8'h00, 6'd10, 1'b1, 1'b0);
    repeat (4) send_request(OP_REPLACE, 8'h00, 6'd0, 1'b0, 1'b0);
    send_request(OP_REFER,   8'h00, 6'd21, 1'b0, 1'b0);
    // all referenced and clean: third pass picks
    send_request(OP_INSERT,  8'h01, 6'd7,  1'b1, 1'b0);
    send_request(OP_INSERT,  8'h02, 6'd56, 1'b1, 1'b0);
    repeat (2) send_request(OP_REPLACE, 8'h00, 6'd0, 1'b0, 1'b0);
    // all referenced and dirty: fourth pass picks
    send_request(OP_INSERT,  8'hff, 6'd33, 1'b1, 1'b1);
    send_request(OP_INSERT,  8'h80, 6'd12, 1'b1, 1'b1);
    repeat (2) send_request(OP_REPLACE, 8'h00, 6'd0, 1'b0, 1'b0);
  endtask

  // Mostly well-formed traffic, biased per chunk to fill, churn or drain
  task automatic run_random();
    int                 ins_w, pick;
    logic [OP_W-1:0]    op;
    logic [PID_W-1:0]   pid;
    logic [FRAME_W-1:0] f;
    bit                 r, d;
    ins_w = 65;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i > 0 && i % 40 == 0)
        case ($urandom_range(0, 2))
          0:       ins_w = 65;
          1:       ins_w = 35;
          default: ins_w = 10;
        endcase
      pid = PID_W'($urandom_range(0, 255));
      r   = 1'($urandom_range(0, 1));
      d   = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 8) begin
        // noise: any code, any frame
        send_request(OP_W'($urandom_range(0, 3)), pid,
                     FRAME_W'($urandom_range(0, FRAMES - 1)), r, d);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < ins_w)
          op = (sb.depth == FRAMES) ? OP_REPLACE : OP_INSERT;
        else if (pick < ins_w + 30)
          op = (sb.depth == 0) ? OP_INSERT : OP_REFER;
        else
          op = (sb.depth == 0) ? OP_INSERT : OP_REPLACE;
        f = pick_frame(op != OP_INSERT);
        send_request(op, pid, f, r, d);
      end
    end
  endtask

  // Result side: random stalls, one long hold-off
  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = quiet_out ? 0 : $urandom_range(0, 18);
      if (!held && results_seen == HOLD_OFF_AT) begin
        stall = HOLD_OFF_CYCLES;
        held  = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tuser, out_tdata[FRAME_W-1:0],
                      out_tdata[OUT_FIELD_W-1:FRAME_W],
                      out_tdata[OUT_TDATA_W-1:OUT_FIELD_W]);
      results_seen++;
      if ($urandom_range(0, 29) == 0) quiet_out = ~quiet_out;
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d inserts, %0d references, %0d replaces and a few unused codes.",
             sb.n_ins, sb.n_ref, sb.n_rep);
    $display("%0d victims chosen, %0d error or empty-ring answers, ring peaked at %0d of %0d.",
             sb.n_victims, sb.n_flagged, sb.peak, FRAMES);
    if (sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
